// ===== rtl/edge_timed_uart_receiver_top_macros.svh =====
`ifndef EDGE_TIMED_UART_RECEIVER_TOP_MACROS_SVH
`define EDGE_TIMED_UART_RECEIVER_TOP_MACROS_SVH

// Same-cycle implication, checked out of reset
`define ETURX_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("eturx: same-cycle check failed");

// Next-cycle implication, checked out of reset
`define ETURX_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("eturx: next-cycle check failed");

`endif

// ===== rtl/eturx_pkg.sv =====
`default_nettype none

package eturx_pkg;

   localparam int unsigned CSR_INDEX_W = 1;
   localparam int unsigned CSR_DATA_W  = 8;

   localparam logic [CSR_INDEX_W-1:0] CSR_EDGE_MARGIN    = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DATA_BIT_COUNT = 1'b1;

   localparam logic [7:0] EDGE_MARGIN_RESET    = 8'd41;
   localparam logic [3:0] DATA_BIT_COUNT_RESET = 4'd8;
   localparam logic [7:0] PERIODS_RESET        = 8'hFF;

   localparam logic KIND_EDGE = 1'b0;
   localparam logic KIND_TICK = 1'b1;

   typedef struct packed {
      logic       kind;
      logic [7:0] timer_count;
      logic       tick_pending;
      logic       line_level;
   } event_type;

   typedef struct packed {
      logic       emit;
      logic [7:0] received_byte;
   } result_type;

   // Set a run of low bits starting at pos; bits beyond position 7 drop out
   function automatic logic [7:0] fill_run(input logic [7:0] byte_val,
                                           input logic [7:0] run,
                                           input logic [3:0] pos);
      logic [7:0]  ones;
      logic [15:0] shifted;
      begin
         if (run >= 8'd8) begin
            ones = 8'hFF;
         end else begin
            ones = (8'd1 << run[2:0]) - 8'd1;
         end
         shifted = {8'd0, ones} << pos[2:0];
         if (pos < 4'd8) begin
            fill_run = byte_val | shifted[7:0];
         end else begin
            fill_run = byte_val;
         end
      end
   endfunction

endpackage

`default_nettype wire

// ===== rtl/eturx_in_stage.sv =====
`default_nettype none

module eturx_in_stage (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire eturx_pkg::event_type req_event,
   input  wire logic                 advance,
   output logic                      evt_valid,
   output eturx_pkg::event_type      evt
);
   import eturx_pkg::*;

   logic      valid_ff, valid_in;
   event_type evt_ff;

   assign req_ready = !valid_ff || advance;
   assign evt_valid = valid_ff;
   assign evt       = evt_ff;

   always_comb begin
      valid_in = valid_ff;
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         evt_ff <= req_event;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/eturx_core.sv =====
`default_nettype none

`include "edge_timed_uart_receiver_top_macros.svh"

module eturx_core (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   evt_valid,
   input  wire eturx_pkg::event_type                   evt,
   input  wire logic                                   advance,
   output eturx_pkg::result_type                       result,
   input  wire logic                                   csr_write_enable,
   input  wire logic [eturx_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire logic [eturx_pkg::CSR_DATA_W-1:0]       csr_write_data
);
   import eturx_pkg::*;

   logic [7:0] edge_margin_ff;
   logic [3:0] data_bit_count_ff;

   logic       armed_ff, armed_in;
   logic [7:0] periods_ff, periods_in;
   logic [3:0] bits_ff, bits_in;
   logic [7:0] byte_ff, byte_in;

   logic [7:0] run_edge, run_tick, run;
   logic [7:0] filled;
   logic [8:0] total;
   logic       reached;
   logic       late_edge, early_edge;

   always_ff @(posedge clock) begin
      if (reset) begin
         edge_margin_ff    <= EDGE_MARGIN_RESET;
         data_bit_count_ff <= DATA_BIT_COUNT_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_EDGE_MARGIN:    edge_margin_ff    <= csr_write_data[7:0];
            CSR_DATA_BIT_COUNT: data_bit_count_ff <= csr_write_data[3:0];
            default: begin
            end
         endcase
      end
   end

   // Partial period: late edge closes one, early edge with a pending tick too
   assign late_edge  = evt.timer_count > edge_margin_ff;
   assign early_edge = evt.tick_pending && (evt.timer_count < edge_margin_ff);
   assign run_edge   = periods_ff + {7'd0, late_edge} + {7'd0, early_edge};
   assign run_tick   = periods_ff + 8'd1;
   assign run        = (evt.kind == KIND_TICK) ? run_tick : run_edge;
   assign filled     = fill_run(byte_ff, run, bits_ff);
   assign total      = {5'd0, bits_ff} + {1'b0, run};
   assign reached    = total >= {5'd0, data_bit_count_ff};

   always_comb begin
      armed_in             = armed_ff;
      periods_in           = periods_ff;
      bits_in              = bits_ff;
      byte_in              = byte_ff;
      result.emit          = 1'b0;
      result.received_byte = byte_ff;
      if (evt_valid && !armed_ff) begin
         if (evt.kind == KIND_EDGE) begin
            armed_in = 1'b1;
         end
      end else if (evt_valid) begin
         if (evt.kind == KIND_EDGE) begin
            result.received_byte = evt.line_level ? byte_ff : filled;
            if (reached) begin
               result.emit = 1'b1;
               armed_in    = 1'b0;
               periods_in  = PERIODS_RESET;
               bits_in     = 4'd0;
               byte_in     = 8'd0;
            end else begin
               periods_in = 8'd0;
               bits_in    = total[3:0];
               byte_in    = result.received_byte;
            end
         end else begin
            result.received_byte = filled;
            if (reached && evt.line_level) begin
               result.emit = 1'b1;
               armed_in    = 1'b0;
               periods_in  = PERIODS_RESET;
               bits_in     = 4'd0;
               byte_in     = 8'd0;
            end else begin
               periods_in = run_tick;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff   <= 1'b0;
         periods_ff <= PERIODS_RESET;
         bits_ff    <= 4'd0;
         byte_ff    <= 8'd0;
      end else if (advance) begin
         armed_ff   <= armed_in;
         periods_ff <= periods_in;
         bits_ff    <= bits_in;
         byte_ff    <= byte_in;
      end
   end

   `ETURX_ASSERT_NEXT(a_emit_disarms, clock, reset, advance && result.emit, !armed_ff)
   `ETURX_ASSERT_NOW(a_idle_is_clear, clock, reset, !armed_ff,
      bits_ff == 4'd0 && periods_ff == PERIODS_RESET && byte_ff == 8'd0)
   `ETURX_ASSERT_NOW(a_no_emit_when_idle, clock, reset, !armed_ff, !result.emit)

endmodule

`default_nettype wire

// ===== rtl/eturx_out_stage.sv =====
`default_nettype none

module eturx_out_stage (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire eturx_pkg::result_type result,
   input  wire logic                  load,
   output logic                       out_free,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [7:0]                 rsp_received_byte
);
   import eturx_pkg::*;

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff;

   assign out_free          = !valid_ff || rsp_ready;
   assign rsp_valid         = valid_ff;
   assign rsp_received_byte = byte_ff;

   always_comb begin
      valid_in = valid_ff;
      if (load && result.emit) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && result.emit) begin
         byte_ff <= result.received_byte;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/edge_timed_uart_receiver_top.sv =====
`default_nettype none

// Edge-timed UART receiver: each request is one line event (an edge or a
// bit-period tick) and one request is taken every cycle, except while an
// event that completes a character waits for a full result register; a
// completed character appears on the response channel once the request that
// finishes it has passed the input register, then the result register. The
// receiver state (period count, bit count, byte being built) is updated as
// an event moves from the input register to the result register. The result
// register lets new requests in while a character waits to be taken. Write
// the margin and data bit count only with no request in flight.
module edge_timed_uart_receiver_top (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic                              req_kind,
   input  wire logic [7:0]                        req_timer_count,
   input  wire logic                              req_tick_pending,
   input  wire logic                              req_line_level,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [7:0]                             rsp_received_byte,
   input  wire logic                              csr_write_enable,
   input  wire logic [eturx_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [eturx_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   import eturx_pkg::*;

   event_type  req_event, evt;
   result_type result;
   logic       evt_valid, advance, out_free;

   assign req_event.kind         = req_kind;
   assign req_event.timer_count  = req_timer_count;
   assign req_event.tick_pending = req_tick_pending;
   assign req_event.line_level   = req_line_level;

   // Hold the event only when it would emit into a full result register
   assign advance = evt_valid && (!result.emit || out_free);

   eturx_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_event (req_event),
      .advance   (advance),
      .evt_valid (evt_valid),
      .evt       (evt)
   );

   eturx_core u_core (
      .clock            (clock),
      .reset            (reset),
      .evt_valid        (evt_valid),
      .evt              (evt),
      .advance          (advance),
      .result           (result),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   eturx_out_stage u_out_stage (
      .clock             (clock),
      .reset             (reset),
      .result            (result),
      .load              (advance),
      .out_free          (out_free),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_received_byte (rsp_received_byte)
   );

endmodule

`default_nettype wire

// ===== dv/edge_timed_uart_receiver_checker.sv =====
module edge_timed_uart_receiver_checker (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   input  wire logic                              req_ready,
   input  wire logic                              req_kind,
   input  wire logic [7:0]                        req_timer_count,
   input  wire logic                              req_tick_pending,
   input  wire logic                              req_line_level,
   input  wire logic                              rsp_valid,
   input  wire logic                              rsp_ready,
   input  wire logic [7:0]                        rsp_received_byte,
   input  wire logic                              csr_write_enable,
   input  wire logic [eturx_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [eturx_pkg::CSR_DATA_W-1:0]  csr_write_data,
   input  wire logic                              final_check,
   output int unsigned                            pending_chars,
   output int unsigned                            fail_count
);
   import eturx_pkg::*;

   logic [7:0] margin;
   logic [3:0] bit_limit;
   logic       armed;
   logic [7:0] periods;
   logic [3:0] bits_rx;
   logic [7:0] assembled;

   logic [7:0] expected_chars[$];
   logic [7:0] want;
   logic [7:0] new_char;
   bit         new_emit;
   bit         final_done;
   event_type  req_event;

   initial begin
      fail_count    = 0;
      pending_chars = 0;
      final_done    = 1'b0;
   end

   task automatic report_mismatch(input string what);
      fail_count++;
      if (fail_count <= 50) begin
         $display("%0t: uart rx check: %s", $time, what);
      end
   endtask

   // OR a run of ones into the byte at pos; anything from bit 8 upwards drops out
   function automatic logic [7:0] merge_run(input logic [7:0] byte_in,
                                            input int unsigned run,
                                            input int unsigned pos);
      logic [15:0] ones;
      logic [15:0] spread;
      ones = (run >= 8) ? 16'h00FF : ((16'd1 << run) - 16'd1);
      spread = ones << (pos & 7);
      merge_run = (pos < 8) ? (byte_in | spread[7:0]) : byte_in;
   endfunction

   task automatic close_char(output bit emits, output logic [7:0] char_out);
      emits     = 1'b1;
      char_out  = assembled;
      armed     = 1'b0;
      periods   = PERIODS_RESET;
      bits_rx   = '0;
      assembled = '0;
   endtask

   task automatic decode_event(input event_type ev, output bit emits,
                               output logic [7:0] char_out);
      int unsigned total;
      emits    = 1'b0;
      char_out = '0;
      if (ev.kind == KIND_EDGE) begin
         if (!armed) begin
            armed = 1'b1;
         end else begin
            if (ev.timer_count > margin) periods = periods + 8'd1;
            if (ev.tick_pending && ev.timer_count < margin) periods = periods + 8'd1;
            // line now low, so the run just closed was high
            if (!ev.line_level) assembled = merge_run(assembled, periods, bits_rx);
            total   = bits_rx + periods;
            periods = '0;
            if (total >= bit_limit) begin
               close_char(emits, char_out);
            end else begin
               bits_rx = total[3:0];
            end
         end
      end else if (armed) begin
         periods = periods + 8'd1;
         total   = bits_rx + periods;
         if (total >= bit_limit && ev.line_level) begin
            assembled = merge_run(assembled, periods, bits_rx);
            close_char(emits, char_out);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         margin    = EDGE_MARGIN_RESET;
         bit_limit = DATA_BIT_COUNT_RESET;
         armed     = 1'b0;
         periods   = PERIODS_RESET;
         bits_rx   = '0;
         assembled = '0;
         expected_chars.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_chars.size() == 0) begin
               report_mismatch($sformatf("unexpected character 0x%02h",
                                         rsp_received_byte));
            end else begin
               want = expected_chars.pop_front();
               if (rsp_received_byte !== want) begin
                  report_mismatch($sformatf("received_byte 0x%02h, expected 0x%02h",
                                            rsp_received_byte, want));
               end
            end
         end
         if (csr_write_enable) begin
            case (csr_index)
               CSR_EDGE_MARGIN:    margin = csr_write_data;
               CSR_DATA_BIT_COUNT: bit_limit = csr_write_data[3:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            req_event = '{kind: req_kind, timer_count: req_timer_count,
                          tick_pending: req_tick_pending, line_level: req_line_level};
            decode_event(req_event, new_emit, new_char);
            if (new_emit) expected_chars.push_back(new_char);
         end
         if (final_check && !final_done) begin
            final_done = 1'b1;
            if (expected_chars.size() != 0) begin
               report_mismatch($sformatf("%0d characters never arrived",
                                         expected_chars.size()));
            end
         end
      end
      pending_chars <= expected_chars.size();
   end

endmodule

// ===== dv/tb_edge_timed_uart_receiver_top.sv =====
module tb_edge_timed_uart_receiver_top;
   import eturx_pkg::*;

   typedef enum int unsigned {
      CLOSE_BY_TICK,
      CLOSE_BY_PENDING,
      CLOSE_BY_LATE_EDGE
   } boundary_style_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic                   req_kind;
   logic [7:0]             req_timer_count;
   logic                   req_tick_pending;
   logic                   req_line_level;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [7:0]             rsp_received_byte;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;
   logic                   final_check;
   int unsigned            pending_chars;
   int unsigned            fail_count;

   int unsigned            items_sent = 0;
   bit                     req_calm = 1'b0;
   bit                     rsp_calm = 1'b0;
   int unsigned            rsp_hold = 0;
   logic [7:0]             cur_margin;
   logic [3:0]             cur_limit;

   always #4 clock = ~clock;

   edge_timed_uart_receiver_top i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_kind          (req_kind),
      .req_timer_count   (req_timer_count),
      .req_tick_pending  (req_tick_pending),
      .req_line_level    (req_line_level),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_received_byte (rsp_received_byte),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   edge_timed_uart_receiver_checker i_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_kind          (req_kind),
      .req_timer_count   (req_timer_count),
      .req_tick_pending  (req_tick_pending),
      .req_line_level    (req_line_level),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_received_byte (rsp_received_byte),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .final_check       (final_check),
      .pending_chars     (pending_chars),
      .fail_count        (fail_count)
   );

   // Mostly short gaps, now and then a long one
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) pick_gap = 0;
      else if (r < 85) pick_gap = $urandom_range(1, 3);
      else if (r < 97) pick_gap = $urandom_range(4, 12);
      else pick_gap = $urandom_range(13, 60);
   endfunction

   always @(posedge clock) begin
      if ($urandom_range(0, 499) == 0) rsp_calm <= !rsp_calm;
      if (rsp_hold > 0) begin
         rsp_ready <= 1'b0;
         rsp_hold  <= rsp_hold - 1;
      end else begin
         rsp_ready <= 1'b1;
         if (!rsp_calm && $urandom_range(0, 3) == 0) rsp_hold <= pick_gap();
      end
   end

   // Leaves valid high on return so a back-to-back request needs no second drive
   task automatic send_event(input logic kind, input logic [7:0] count,
                             input logic pend, input logic level);
      int unsigned gap;
      if ($urandom_range(0, 199) == 0) req_calm = !req_calm;
      gap = req_calm ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_kind         <= kind;
      req_timer_count  <= count;
      req_tick_pending <= pend;
      req_line_level   <= level;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   task automatic send_noise_event();
      send_event(1'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
   endtask

   // Close one bit period; a level change needs an edge, otherwise a tick
   task automatic cross_boundary(input logic level_before, input logic level_after);
      boundary_style_type style;
      if ($urandom_range(0, 29) == 0) send_noise_event();
      if (level_before == level_after) begin
         send_event(KIND_TICK, 8'($urandom), 1'($urandom), level_after);
      end else begin
         style = boundary_style_type'($urandom_range(0, 2));
         if (style == CLOSE_BY_PENDING && cur_margin == 8'd0) style = CLOSE_BY_TICK;
         if (style == CLOSE_BY_LATE_EDGE && cur_margin == 8'hFF) style = CLOSE_BY_TICK;
         case (style)
            CLOSE_BY_TICK: begin
               send_event(KIND_TICK, 8'($urandom), 1'($urandom), level_before);
               send_event(KIND_EDGE, 8'($urandom_range(0, cur_margin)), 1'b0,
                          level_after);
            end
            CLOSE_BY_PENDING:
               send_event(KIND_EDGE, 8'($urandom_range(0, cur_margin - 1)), 1'b1,
                          level_after);
            default:
               send_event(KIND_EDGE, 8'($urandom_range(cur_margin + 1, 255)),
                          1'($urandom), level_after);
         endcase
      end
   endtask

   task automatic send_char(input int unsigned nbits);
      logic [15:0] data_bits;
      logic        level_now;
      logic        level_next;
      data_bits = 16'($urandom);
      send_event(KIND_EDGE, 8'($urandom), 1'($urandom), 1'b0);
      level_now = 1'b0;
      for (int unsigned k = 0; k <= nbits; k++) begin
         level_next = (k == nbits) ? 1'b1 : data_bits[k];
         cross_boundary(level_now, level_next);
         level_now = level_next;
      end
      repeat ($urandom_range(1, 2)) send_event(KIND_TICK, 8'($urandom), 1'($urandom), 1'b1);
   endtask

   // Drop valid and wait for the pipeline to empty before touching the registers
   task automatic settle();
      int unsigned waited;
      waited = 0;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_chars != 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic program_receiver(input logic [7:0] margin_val, input logic [3:0] limit_val);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_EDGE_MARGIN;
      csr_write_data   <= margin_val;
      @(posedge clock);
      csr_index        <= CSR_DATA_BIT_COUNT;
      csr_write_data   <= {4'd0, limit_val};
      @(posedge clock);
      csr_write_enable <= 1'b0;
      cur_margin = margin_val;
      cur_limit  = limit_val;
   endtask

   initial begin
      logic [7:0]  margin_plan [8];
      logic [3:0]  limit_plan  [8];
      int unsigned phase_end;

      margin_plan = '{8'd0, 8'd255, 8'd41, 8'd128, 8'd7, 8'($urandom), 8'($urandom),
                      8'($urandom)};
      limit_plan  = '{4'd8, 4'd5, 4'd0, 4'd15, 4'd6, 4'd7, 4'd9,
                      4'($urandom_range(5, 8))};

      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_kind         <= KIND_EDGE;
      req_timer_count  <= '0;
      req_tick_pending <= 1'b0;
      req_line_level   <= 1'b1;
      csr_write_enable <= 1'b0;
      csr_index        <= CSR_EDGE_MARGIN;
      csr_write_data   <= '0;
      final_check      <= 1'b0;
      cur_margin = EDGE_MARGIN_RESET;
      cur_limit  = DATA_BIT_COUNT_RESET;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // tick while idle is dropped, any edge while idle only arms
      send_event(KIND_TICK, 8'hFF, 1'b1, 1'b1);
      send_event(KIND_EDGE, 8'hFF, 1'b1, 1'b1);
      // count equal to margin with a tick pending: no extra period, run spills past bit 7
      send_event(KIND_EDGE, 8'd41, 1'b1, 1'b0);
      // period counter wraps from 255, then the count overshoots the limit
      send_event(KIND_EDGE, 8'd0, 1'b0, 1'b0);
      send_event(KIND_EDGE, 8'd255, 1'b0, 1'b1);
      repeat (9) send_event(KIND_TICK, 8'd0, 1'b0, 1'b0);
      send_event(KIND_EDGE, 8'd0, 1'b1, 1'b1);
      // close a character with a tick while the line is high
      send_event(KIND_EDGE, 8'd200, 1'b0, 1'b0);
      send_event(KIND_TICK, 8'd128, 1'b1, 1'b0);
      send_event(KIND_EDGE, 8'd100, 1'b0, 1'b1);
      repeat (7) send_event(KIND_TICK, 8'd0, 1'b0, 1'b1);

      for (int p = 0; p < 8; p++) begin
         settle();
         program_receiver(margin_plan[p], limit_plan[p]);
         phase_end = items_sent + 240;
         while (items_sent < phase_end) begin
            if ($urandom_range(0, 3) != 0) begin
               send_char(cur_limit);
            end else begin
               repeat ($urandom_range(1, 6)) send_noise_event();
            end
         end
      end

      settle();
      final_check <= 1'b1;
      repeat (3) @(posedge clock);
      @(negedge clock);
      if (fail_count == 0) begin
         $display("tb_edge_timed_uart_receiver_top OK");
      end else begin
         $display("tb_edge_timed_uart_receiver_top NOT OK");
      end
      $finish;
   end

   initial begin
      #10000000;
      $display("tb_edge_timed_uart_receiver_top NOT OK");
      $finish;
   end

endmodule
